>>> rtl/rx_fifo_with_xon_xoff_unit_macros.svh
// Assertion macros used by the receive FIFO top level.
`ifndef RX_FIFO_WITH_XON_XOFF_UNIT_MACROS_SVH
`define RX_FIFO_WITH_XON_XOFF_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk_i outside of reset.
`define RXFF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside of reset.
`define RXFF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rxff_pkg.sv
// Types, constants and helpers of the receive FIFO with XON/XOFF flow control.
`default_nettype none
package rxff_pkg;

  localparam int unsigned DepthDefault = 256;

  localparam int unsigned DataW  = 8;
  localparam int unsigned XoffW  = 9;
  localparam int unsigned XonW   = 8;
  localparam int unsigned FillW  = 9;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW   = 9;

  localparam logic [XoffW-1:0] XoffReset = 9'd192;
  localparam logic [XonW-1:0]  XonReset  = 8'd64;

  localparam logic [CfgIdxW-1:0] CfgXoff = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgXon  = 1'b1;

  typedef enum logic {
    OP_RECV = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    FLOW_NONE = 2'd0,
    FLOW_XON  = 2'd1,
    FLOW_XOFF = 2'd2
  } flow_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_FETCH = 1'b1
  } st_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic push;
    logic pop;
    logic load_direct;
    logic load_mem;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic out_valid;
  } status_t;

  function automatic logic [DataW-1:0] fold_upper(input logic [DataW-1:0] c);
    logic [DataW-1:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7a) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/rxff_ctrl.sv
// Controller state machine of the receive FIFO.
`default_nettype none
module rxff_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             opcode_i,
  input  wire logic             out_stall_i,
  input  wire rxff_pkg::status_t status_i,
  output logic                  in_stall_o,
  output rxff_pkg::cmd_t        cmd_o
);

  rxff_pkg::st_e state_q, state_d;
  logic          can_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rxff_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // The output register may be loaded when it is empty or being drained.
  assign can_load = !status_i.out_valid || !out_stall_i;

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    case (state_q)
      rxff_pkg::ST_IDLE: begin
        in_stall_o = !can_load;
        if (in_valid_i && can_load) begin
          cmd_o.accept = 1'b1;
          if (opcode_i == rxff_pkg::OP_READ && !status_i.empty) begin
            cmd_o.pop = 1'b1;
            state_d   = rxff_pkg::ST_FETCH;
          end else begin
            cmd_o.push        = (opcode_i == rxff_pkg::OP_RECV) && !status_i.full;
            cmd_o.load_direct = 1'b1;
          end
        end
      end
      rxff_pkg::ST_FETCH: begin
        // The output register was freed when the pop was accepted.
        cmd_o.load_mem = 1'b1;
        state_d        = rxff_pkg::ST_IDLE;
      end
      default: begin
        state_d = rxff_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/rxff_dp.sv
// Datapath of the receive FIFO: byte memory, pointers, count, levels and result register.
`default_nettype none
module rxff_dp #(
  parameter int unsigned DEPTH = rxff_pkg::DepthDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         opcode_i,
  input  wire logic [rxff_pkg::DataW-1:0]   rx_byte_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [rxff_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [rxff_pkg::CfgW-1:0]    cfg_wdata_i,
  input  wire logic                         out_stall_i,
  input  wire rxff_pkg::cmd_t               cmd_i,
  output rxff_pkg::status_t                 status_o,
  output logic [rxff_pkg::DataW-1:0]        read_data_o,
  output logic                              read_valid_o,
  output logic [1:0]                        flow_request_o,
  output logic                              overflow_o,
  output logic [rxff_pkg::FillW-1:0]        fill_count_o,
  output logic                              out_valid_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > rxff_pkg::XoffW) ? CntW : rxff_pkg::XoffW;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [rxff_pkg::DataW-1:0] mem [DEPTH];
  logic [rxff_pkg::DataW-1:0] rdata_q;

  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d, cnt_inc, cnt_dec;
  logic [rxff_pkg::XoffW-1:0] xoff_q;
  logic [rxff_pkg::XonW-1:0]  xon_q;
  rxff_pkg::flow_e            flow_d;

  rxff_pkg::flow_e            out_flow_q;
  logic [rxff_pkg::DataW-1:0] out_data_q;
  logic                       out_rvalid_q, out_ovf_q, out_valid_q;
  logic [rxff_pkg::FillW-1:0] out_count_q;

  assign cnt_inc = count_q + CntW'(1);
  assign cnt_dec = count_q - CntW'(1);

  always_comb begin
    count_d = count_q;
    if (cmd_i.push) begin
      count_d = cnt_inc;
    end else if (cmd_i.pop) begin
      count_d = cnt_dec;
    end
  end

  always_comb begin
    flow_d = rxff_pkg::FLOW_NONE;
    if (cmd_i.push && CmpW'(cnt_inc) == CmpW'(xoff_q)) begin
      flow_d = rxff_pkg::FLOW_XOFF;
    end else if (cmd_i.pop && CmpW'(cnt_dec) == CmpW'(xon_q)) begin
      flow_d = rxff_pkg::FLOW_XON;
    end
  end

  // Byte memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[wr_ptr_q] <= rxff_pkg::fold_upper(rx_byte_i);
    end
    if (cmd_i.pop) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (cmd_i.push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (cmd_i.pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xoff_q <= rxff_pkg::XoffReset;
      xon_q  <= rxff_pkg::XonReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rxff_pkg::CfgXoff: xoff_q <= cfg_wdata_i;
        rxff_pkg::CfgXon:  xon_q  <= cfg_wdata_i[rxff_pkg::XonW-1:0];
        default: ;
      endcase
    end
  end

  // Result fields other than the data are captured when the item is accepted.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      out_flow_q   <= flow_d;
      out_count_q  <= rxff_pkg::FillW'(count_d);
      out_rvalid_q <= cmd_i.pop;
      out_ovf_q    <= (opcode_i == rxff_pkg::OP_RECV) && status_o.full;
    end
    if (cmd_i.load_direct) begin
      out_data_q <= '0;
    end else if (cmd_i.load_mem) begin
      out_data_q <= rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_direct || cmd_i.load_mem) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.empty     = (count_q == '0);
  assign status_o.full      = (count_q == CntFull);
  assign status_o.out_valid = out_valid_q;

  assign read_data_o    = out_data_q;
  assign read_valid_o   = out_rvalid_q;
  assign flow_request_o = out_flow_q;
  assign overflow_o     = out_ovf_q;
  assign fill_count_o   = out_count_q;
  assign out_valid_o    = out_valid_q;

endmodule
`default_nettype wire

>>> rtl/rx_fifo_with_xon_xoff_unit.sv
// Top level of the receive FIFO with XON/XOFF flow control.
// Receive FIFO of DEPTH bytes with software flow control. A receive item
// (opcode 0) stores its byte folded to upper case; a read item (opcode 1)
// pops the oldest byte. Each item gives one result with the fill count after
// it, an XOFF request when a receive brings the count to xoff_level, an XON
// request when a read brings it to xon_level, and an overflow flag when a
// receive finds the buffer full. A read that pops a byte passes through the
// fetch state, since the byte memory has a registered read port. The
// result register lets the next item be accepted in the cycle its
// predecessor's result is taken. The memory needs no clearing after reset.
// Write xoff_level (index 0) and xon_level (index 1) only while the block is
// idle.
`default_nettype none
`include "rx_fifo_with_xon_xoff_unit_macros.svh"
module rx_fifo_with_xon_xoff_unit #(
  parameter int unsigned DEPTH = rxff_pkg::DepthDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         opcode_i,
  input  wire logic [rxff_pkg::DataW-1:0]   rx_byte_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [rxff_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [rxff_pkg::CfgW-1:0]    cfg_wdata_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [rxff_pkg::DataW-1:0]        read_data_o,
  output logic                              read_valid_o,
  output logic [1:0]                        flow_request_o,
  output logic                              overflow_o,
  output logic [rxff_pkg::FillW-1:0]        fill_count_o
);

  rxff_pkg::cmd_t    cmd;
  rxff_pkg::status_t status;

  rxff_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (opcode_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  rxff_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .opcode_i       (opcode_i),
    .rx_byte_i      (rx_byte_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_stall_i    (out_stall_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .read_data_o    (read_data_o),
    .read_valid_o   (read_valid_o),
    .flow_request_o (flow_request_o),
    .overflow_o     (overflow_o),
    .fill_count_o   (fill_count_o),
    .out_valid_o    (out_valid_o)
  );

  // A dropped receive reports neither a flow request nor read data.
  `RXFF_ASSERT_IMP(a_ovf_clean, out_valid_o && overflow_o,
    !read_valid_o && flow_request_o == rxff_pkg::FLOW_NONE, "overflow result is not clean")

  // A popping read is followed in the next cycle by the fetch that loads its byte, with the input stalled.
  `RXFF_ASSERT_NXT(a_pop_fetch, cmd.pop, cmd.load_mem && in_stall_o, "pop not followed by fetch")

  // A receive accepted while full produces an overflow result.
  `RXFF_ASSERT_NXT(a_full_drop,
    in_valid_i && !in_stall_o && opcode_i == rxff_pkg::OP_RECV && status.full,
    out_valid_o && overflow_o, "receive into full buffer not flagged")

endmodule
`default_nettype wire
